[sv/gcc_pkg.sv]
// Shared constants, types and reset values for the greedy coin change block.
`timescale 1ns / 1ps
`default_nettype none

package gcc_pkg;

    // Fixed geometry of the block.
    localparam int NUM_COINS   = 8;
    localparam int AMOUNT_BITS = 20;
    localparam int VALUE_BITS  = 16;
    localparam int SLOT_BITS   = 3;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 5;
    localparam int STEP_BITS   = $clog2(AMOUNT_BITS);

    typedef logic [VALUE_BITS-1:0]  t_value;
    typedef logic [AMOUNT_BITS-1:0] t_amount;
    typedef logic [SLOT_BITS-1:0]   t_slot;
    typedef logic [VALUE_BITS:0]    t_bound;

    localparam t_slot LAST_SLOT = SLOT_BITS'(NUM_COINS - 1);

    // Denominations after reset, slot 0 first.
    localparam t_value COIN_RESET [NUM_COINS] = '{
        16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1
    };

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[sv/greedy_coin_change.sv]
// Top level of the greedy coin change block: registers, sequencer and result words.
`timescale 1ns / 1ps
`default_nettype none

// Splits an amount in cents greedily over eight configurable denominations and
// returns eight result words, one per slot in slot order, each with the slot's
// value, the pieces chosen, an exact flag and a last flag. One amount is handled
// at a time and i_valid is not taken while one is in progress. The sequencer
// scans the slots to find the next smaller distinct value, then a shared
// bit-serial divider takes the pieces and the remainder; this repeats for each
// distinct nonzero value, and the result words can be held by i_ready on the
// output. Denominations are written over the APB port at byte address 4*slot;
// a zero value marks an unused slot, which reports a count of zero.
module greedy_coin_change
    import gcc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Amount channel
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire  [AMOUNT_BITS-1:0] i_amount,
    // Result channel
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [SLOT_BITS-1:0]   o_slot,
    output logic [VALUE_BITS-1:0]  o_coin_value,
    output logic [AMOUNT_BITS-1:0] o_coin_count,
    output logic                   o_exact,
    output logic                   o_last,
    // Configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [ADDR_BITS-1:0]   paddr,
    input  wire  [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready
);

    t_state  r_state, n_state;
    t_value  r_coin [NUM_COINS];
    t_value  r_vals [NUM_COINS];
    t_amount r_cnt  [NUM_COINS];
    t_amount r_rem;
    t_bound  r_bound;
    t_value  r_best;
    t_slot   r_idx;

    t_slot   w_reg_idx;
    logic    w_take;
    t_value  w_best;
    logic    w_scan_last;
    logic    w_div_start;
    logic    w_div_done;
    t_amount w_quot;
    t_value  w_remd;

    // Configuration registers.
    assign w_reg_idx = paddr[ADDR_BITS-1:2];
    assign pready    = 1'b1;
    assign prdata    = {{(DATA_BITS - VALUE_BITS){1'b0}}, r_coin[w_reg_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_COINS; j++) begin
                r_coin[j] <= COIN_RESET[j];
            end
        end else if (psel && penable && pwrite) begin
            r_coin[w_reg_idx] <= pwdata[VALUE_BITS-1:0];
        end
    end

    // Scan step: is the slot at the head a better candidate below the bound?
    always_comb begin
        w_take = (r_vals[0] != '0) && ({1'b0, r_vals[0]} < r_bound)
                 && (r_vals[0] > r_best);
        w_best = w_take ? r_vals[0] : r_best;
        w_scan_last = (r_state == S_SCAN) && (r_idx == LAST_SLOT);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == LAST_SLOT) begin
                    n_state = (w_best == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_SCAN;
            end
            S_OUT: begin
                if (i_ready && (r_idx == LAST_SLOT)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_valid     = (r_state == S_OUT);
        w_div_start = w_scan_last && (w_best != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers: snapshot of the values, counts, remainder and bound.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_rem   <= i_amount;
                    r_bound <= {1'b1, {VALUE_BITS{1'b0}}};
                    r_best  <= '0;
                    r_idx   <= '0;
                    for (int j = 0; j < NUM_COINS; j++) begin
                        r_vals[j] <= r_coin[j];
                        r_cnt[j]  <= '0;
                    end
                end
            end
            S_SCAN: begin
                // Rotate the snapshot so each slot passes the head once.
                for (int j = 0; j < NUM_COINS; j++) begin
                    r_vals[j] <= r_vals[(j + 1) % NUM_COINS];
                end
                r_best <= w_best;
                r_idx  <= (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
            end
            S_DIV: begin
                if (w_div_done) begin
                    // Every slot holding this value reports the same count.
                    for (int j = 0; j < NUM_COINS; j++) begin
                        if (r_vals[j] == r_best) r_cnt[j] <= w_quot;
                    end
                    r_rem   <= {{(AMOUNT_BITS - VALUE_BITS){1'b0}}, w_remd};
                    r_bound <= {1'b0, r_best};
                    r_best  <= '0;
                    r_idx   <= '0;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    for (int j = 0; j < NUM_COINS; j++) begin
                        r_vals[j] <= r_vals[(j + 1) % NUM_COINS];
                        r_cnt[j]  <= r_cnt[(j + 1) % NUM_COINS];
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
                r_idx <= '0;
            end
        endcase
    end

    // Shared divider for pieces and remainder.
    gcc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_rem),
        .i_divisor   (w_best),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_remd)
    );

    // Result word fields.
    assign o_slot       = r_idx;
    assign o_coin_value = r_vals[0];
    assign o_coin_count = r_cnt[0];
    assign o_exact      = (r_rem == '0);
    assign o_last       = (r_idx == LAST_SLOT);

endmodule

`default_nettype wire

[sv/gcc_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gcc_div
    import gcc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire t_amount i_dividend,
    input  wire t_value  i_divisor,
    output logic         o_done,
    output t_amount      o_quotient,
    output t_value       o_remainder
);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_BITS-1:0]   r_step;
    t_amount                r_q;
    t_value                 r_p;
    t_value                 r_d;

    logic [VALUE_BITS:0]    w_shifted;
    logic [VALUE_BITS:0]    w_diff;
    logic                   w_ge;
    logic                   w_final;

    // One subtract and compare per cycle on the partial remainder.
    always_comb begin
        w_shifted = {r_p, r_q[AMOUNT_BITS-1]};
        w_diff    = w_shifted - {1'b0, r_d};
        w_ge      = (w_shifted >= {1'b0, r_d});
        w_final   = r_busy && (r_step == STEP_BITS'(AMOUNT_BITS - 1));
    end

    // Control: busy flag, step counter and a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= w_final;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_final) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_p <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[AMOUNT_BITS-2:0], w_ge};
            r_p <= w_ge ? w_diff[VALUE_BITS-1:0] : w_shifted[VALUE_BITS-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_p;

endmodule

`default_nettype wire

[bench/change_checker.sv]
// Checker for the greedy coin change block: tracks the denominations, predicts result words, compares.
`timescale 1ns / 1ps

module change_checker
    import gcc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Amount channel
    input  wire                    i_amt_valid,
    input  wire                    i_amt_ready,
    input  wire  [AMOUNT_BITS-1:0] i_amount,
    // Result channel
    input  wire                    i_res_valid,
    input  wire                    i_res_ready,
    input  wire  [SLOT_BITS-1:0]   i_slot,
    input  wire  [VALUE_BITS-1:0]  i_coin_value,
    input  wire  [AMOUNT_BITS-1:0] i_coin_count,
    input  wire                    i_exact,
    input  wire                    i_last,
    // Configuration port
    input  wire                    i_psel,
    input  wire                    i_penable,
    input  wire                    i_pwrite,
    input  wire                    i_pready,
    input  wire  [ADDR_BITS-1:0]   i_paddr,
    input  wire  [DATA_BITS-1:0]   i_pwdata,
    // Status toward the testbench top
    output logic [31:0]            o_fail_count,
    output logic [31:0]            o_pending
);

    typedef struct {
        t_slot   slot;
        t_value  coin_value;
        t_amount coin_count;
        logic    exact;
        logic    last;
    } t_change_word;

    t_value       coin_reg [NUM_COINS];
    t_change_word change_due [$];
    int unsigned  mismatches = 0;

    // Greedy split of one amount: queue the word that each slot should report.
    function automatic void split_amount(input t_amount amount);
        t_bound       bound;
        t_value       best;
        logic [31:0]  rest;
        t_value       taken_value [NUM_COINS];
        t_amount      taken_count [NUM_COINS];
        int           n_taken;
        t_change_word w;
        rest    = 32'(amount);
        bound   = {1'b1, {VALUE_BITS{1'b0}}};
        n_taken = 0;
        // Walk the distinct nonzero values from the largest down.
        for (int k = 0; k < NUM_COINS; k++) begin
            best = '0;
            for (int s = 0; s < NUM_COINS; s++) begin
                if (coin_reg[s] != '0 && {1'b0, coin_reg[s]} < bound && coin_reg[s] > best)
                    best = coin_reg[s];
            end
            if (best == '0)
                break;
            taken_value[n_taken] = best;
            taken_count[n_taken] = AMOUNT_BITS'(rest / best);
            n_taken++;
            rest  = rest % best;
            bound = {1'b0, best};
        end
        // Every slot holding a value reports the pieces taken of that value.
        for (int s = 0; s < NUM_COINS; s++) begin
            w.slot       = SLOT_BITS'(s);
            w.coin_value = coin_reg[s];
            w.coin_count = '0;
            for (int k = 0; k < n_taken; k++) begin
                if (coin_reg[s] != '0 && taken_value[k] == coin_reg[s])
                    w.coin_count = taken_count[k];
            end
            w.exact = (rest == 0);
            w.last  = (s == NUM_COINS - 1);
            change_due = {change_due, w};
        end
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Compare result words, predict accepted amounts, then follow register writes.
    always @(posedge i_clk) begin : watch
        t_change_word w;
        if (!i_rst_n) begin
            foreach (coin_reg[s]) coin_reg[s] = COIN_RESET[s];
            change_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (change_due.size() == 0) begin
                    $error("result word for slot %0d arrived with nothing expected", i_slot);
                    mismatches++;
                end else begin
                    w = change_due.pop_front();
                    check_field("slot", 32'(w.slot), 32'(i_slot));
                    check_field("coin_value", 32'(w.coin_value), 32'(i_coin_value));
                    check_field("coin_count", 32'(w.coin_count), 32'(i_coin_count));
                    check_field("exact", 32'(w.exact), 32'(i_exact));
                    check_field("last", 32'(w.last), 32'(i_last));
                end
            end
            if (i_amt_valid && i_amt_ready)
                split_amount(i_amount);
            if (i_psel && i_penable && i_pwrite && i_pready &&
                    32'(i_paddr[ADDR_BITS-1:2]) < NUM_COINS)
                coin_reg[i_paddr[ADDR_BITS-1:2]] = i_pwdata[VALUE_BITS-1:0];
        end
        o_fail_count <= mismatches;
        o_pending    <= change_due.size();
    end

endmodule

[bench/testbench.sv]
// Testbench top for the greedy coin change block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import gcc_pkg::*;

    localparam int      QUIET_LIMIT = 5000;
    localparam int      LONG_HOLD   = 400;
    localparam int      ROUNDS      = 8;
    localparam int      ROUND_ITEMS = 52;
    localparam t_amount AMOUNT_MAX  = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [AMOUNT_BITS-1:0] i_amount;
    logic                   o_valid;
    logic                   i_ready;
    logic [SLOT_BITS-1:0]   o_slot;
    logic [VALUE_BITS-1:0]  o_coin_value;
    logic [AMOUNT_BITS-1:0] o_coin_count;
    logic                   o_exact;
    logic                   o_last;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [DATA_BITS-1:0]   pwdata;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;
    logic [31:0]            fail_count;
    logic [31:0]            pending;

    // Denominations being programmed, and the knobs for idling on both sides.
    t_value coins_now [NUM_COINS];
    logic   bursts_on;
    logic   long_hold_req;

    greedy_coin_change DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_amount     (i_amount),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot       (o_slot),
        .o_coin_value (o_coin_value),
        .o_coin_count (o_coin_count),
        .o_exact      (o_exact),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    change_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_amt_valid  (i_valid),
        .i_amt_ready  (o_ready),
        .i_amount     (i_amount),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_slot       (o_slot),
        .i_coin_value (o_coin_value),
        .i_coin_count (o_coin_count),
        .i_exact      (o_exact),
        .i_last       (o_last),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: short random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req <= 1'b0;
                hold_left = LONG_HOLD;
                i_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // End the run when nothing has been accepted for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one amount word and return at the edge that accepts it.
    task automatic send_amount(input t_amount amount);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_amount <= amount;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop sending and wait until every expected result word has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; psel stays up for a following write.
    task automatic write_coin(input int s);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * s);
        pwdata  <= DATA_BITS'(coins_now[s]);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_coins();
        wait_drained();
        for (int s = 0; s < NUM_COINS; s++)
            write_coin(s);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random denominations: unused slots, small and full-range values, duplicates.
    task automatic roll_coins(input int round);
        for (int s = 0; s < NUM_COINS; s++) begin
            case ($urandom_range(0, 5))
                0:       coins_now[s] = '0;
                1:       coins_now[s] = t_value'($urandom_range(1, 9));
                2:       coins_now[s] = t_value'($urandom_range(10, 500));
                3:       coins_now[s] = t_value'($urandom);
                4:       coins_now[s] = '1;
                default: coins_now[s] = (s > 0) ? coins_now[s-1] : t_value'($urandom);
            endcase
        end
        // Odd rounds keep a one-cent piece so that every split comes out exact.
        if (round % 2 == 1)
            coins_now[$urandom_range(0, NUM_COINS - 1)] = 16'd1;
    endtask

    // Amounts: full range, small, sums of the current pieces, zero, the maximum, and edges around a value.
    function automatic t_amount pick_amount();
        logic [31:0] sum;
        t_value      v;
        t_amount     amount;
        sum = '0;
        v   = coins_now[$urandom_range(0, NUM_COINS - 1)];
        case ($urandom_range(0, 5))
            0, 1: amount = t_amount'($urandom);
            2:    amount = t_amount'($urandom_range(0, 1000));
            3, 4: begin
                for (int s = 0; s < NUM_COINS; s++)
                    sum = sum + coins_now[s] * $urandom_range(0, 3);
                amount = t_amount'(sum);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       amount = '0;
                    1:       amount = AMOUNT_MAX;
                    2:       amount = t_amount'(v);
                    3:       amount = t_amount'(v) - 1'b1;
                    default: amount = t_amount'(v) + 1'b1;
                endcase
            end
        endcase
        return amount;
    endfunction

    initial begin : stimulus
        int r;
        int n;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_amount      <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        bursts_on     <= 1'b1;
        long_hold_req <= 1'b0;
        foreach (coins_now[s]) coins_now[s] = COIN_RESET[s];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset denominations: zero, one cent, every piece once, a near miss, two small pieces, the maximum.
        send_amount(20'd0);
        send_amount(20'd1);
        send_amount(20'd388);
        send_amount(20'd199);
        send_amount(20'd3);
        send_amount(AMOUNT_MAX);

        // Unused slots, duplicate values, the largest value, and no one-cent piece.
        coins_now = '{16'd0, 16'd7, 16'd3, 16'd0, 16'd7, 16'hFFFF, 16'd0, 16'd4};
        program_coins();
        send_amount(20'd0);
        send_amount(20'd13);
        send_amount(20'd65546);
        send_amount(20'd2);
        send_amount(AMOUNT_MAX);

        // No usable slot at all.
        coins_now = '{default: 16'd0};
        program_coins();
        send_amount(20'd0);
        send_amount(20'd1);
        send_amount(AMOUNT_MAX);

        // Every slot at the largest value.
        coins_now = '{default: 16'hFFFF};
        program_coins();
        send_amount(20'd0);
        send_amount(20'd65535);
        send_amount(20'd131070);
        send_amount(AMOUNT_MAX);

        // Random rounds, each with its own set of denominations; the last ones run without idling.
        for (r = 0; r < ROUNDS; r++) begin
            if (r == 0)
                foreach (coins_now[s]) coins_now[s] = COIN_RESET[s];
            else
                roll_coins(r);
            program_coins();
            if (r == 2)
                long_hold_req <= 1'b1;
            for (n = 0; n < ROUND_ITEMS; n++) begin
                bursts_on <= (r < ROUNDS - 2) && ((n % 20) < 14);
                if (r == 4 && n == ROUND_ITEMS / 2)
                    wait_drained();
                send_amount(pick_amount());
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[greedy_coin_change.f]
sv/gcc_pkg.sv
sv/gcc_div.sv
sv/greedy_coin_change.sv
bench/change_checker.sv
bench/testbench.sv
